### rtl/rsdb_pkg.sv
// shared types, register codes and constants of the sprite decode blitter
package rsdb_pkg;

    localparam int DEF_MAX_SPRITE_DIM = 1024;
    localparam int DEF_MAX_TARGET_DIM = 4096;
    localparam int TARGET_LIMIT       = 4096;

    localparam int WORD_W      = 16;
    localparam int COUNT_W     = 15;
    localparam int PIX_W       = 12;
    localparam int COLOR_W     = 16;
    localparam int OUT_DATA_W  = 2 * PIX_W + COLOR_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] IDX_SPRITE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPRITE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] IDX_ORIGIN_X      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] IDX_ORIGIN_Y      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] IDX_TARGET_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] IDX_TARGET_HEIGHT = 3'd5;

    localparam logic [10:0] RST_SPRITE_WIDTH  = 11'd16;
    localparam logic [10:0] RST_SPRITE_HEIGHT = 11'd16;
    localparam logic [15:0] RST_ORIGIN_X      = 16'd0;
    localparam logic [15:0] RST_ORIGIN_Y      = 16'd0;
    localparam logic [12:0] RST_TARGET_WIDTH  = 13'd320;
    localparam logic [12:0] RST_TARGET_HEIGHT = 13'd240;

    typedef enum logic [1:0] {
        HDR_EMPTY,
        HDR_SKIP,
        HDR_LITERAL
    } hdr_kind_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        hdr_kind_t          kind;
        logic [COUNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic [10:0] sprite_width;
        logic [10:0] sprite_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [12:0] target_width;
        logic [12:0] target_height;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } back_state_t;

endpackage

### rtl/rle_sprite_decode_blitter_core.sv
// top level of the run-length sprite decoder and pixel blitter
// path: an input beat passes the queue register, then the output register, inside a row or
// with one wrap; a skip over several rows waits for the one-bit-per-cycle width divider
// throughput without output stall: one beat per cycle on the single-wrap path, one per
// divider run otherwise; reset: asynchronous, clears position, run count, queue and output
// valid, and loads the register defaults; there is no clearing pass
module rle_sprite_decode_blitter_core #(
    parameter int MAX_SPRITE_DIM = rsdb_pkg::DEF_MAX_SPRITE_DIM,
    parameter int MAX_TARGET_DIM = rsdb_pkg::DEF_MAX_TARGET_DIM
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsdb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsdb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // code_word [15:0]
    input  logic [rsdb_pkg::WORD_W-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pixel_x [11:0], pixel_y [23:12], pixel_color [39:24]
    output logic [rsdb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // write_pixel [0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import rsdb_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             q_push;
    logic             q_full;
    item_t            push_item;
    logic             q_pop;
    logic             q_valid;
    item_t            head_item;
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
    logic [COLOR_W-1:0] out_color;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                IDX_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[10:0];
                IDX_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[10:0];
                IDX_ORIGIN_X:      cfg_next.origin_x      = cfg_data;
                IDX_ORIGIN_Y:      cfg_next.origin_y      = cfg_data;
                IDX_TARGET_WIDTH:  cfg_next.target_width  = cfg_data[12:0];
                IDX_TARGET_HEIGHT: cfg_next.target_height = cfg_data[12:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_width  <= RST_SPRITE_WIDTH;
            cfg_reg.sprite_height <= RST_SPRITE_HEIGHT;
            cfg_reg.origin_x      <= RST_ORIGIN_X;
            cfg_reg.origin_y      <= RST_ORIGIN_Y;
            cfg_reg.target_width  <= RST_TARGET_WIDTH;
            cfg_reg.target_height <= RST_TARGET_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rsdb_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rsdb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    rsdb_back #(
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
        .MAX_TARGET_DIM (MAX_TARGET_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_wr    (m_axis_tuser),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .out_done  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_color, out_y, out_x};

endmodule

### rtl/rsdb_front.sv
// front end: takes code word beats and classifies them for the queue
module rsdb_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsdb_pkg::WORD_W-1:0]   s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output rsdb_pkg::item_t               q_item
);
    import rsdb_pkg::*;

    logic [COUNT_W-1:0] count;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign count    = s_tdata[COUNT_W-1:0];

    always_comb
    begin
        q_item.word  = s_tdata;
        q_item.count = count;
        if (count == '0)
        begin
            q_item.kind = HDR_EMPTY;
        end
        else if (s_tdata[WORD_W-1])
        begin
            q_item.kind = HDR_LITERAL;
        end
        else
        begin
            q_item.kind = HDR_SKIP;
        end
    end

endmodule

### rtl/rsdb_queue.sv
// short register queue between the front end and the back end
module rsdb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rsdb_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rsdb_pkg::item_t head_item
);
    import rsdb_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/rsdb_div.sv
// restoring divider, one quotient bit per cycle
module rsdb_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] dvs_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    assign shifted   = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial     = shifted - {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DVS_W])
            begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

### rtl/rsdb_back.sv
// back end: position tracking, clipping, frame end and the output register
module rsdb_back #(
    parameter int MAX_SPRITE_DIM = rsdb_pkg::DEF_MAX_SPRITE_DIM,
    parameter int MAX_TARGET_DIM = rsdb_pkg::DEF_MAX_TARGET_DIM
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsdb_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  rsdb_pkg::item_t              q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_wr,
    output logic [rsdb_pkg::PIX_W-1:0]   out_x,
    output logic [rsdb_pkg::PIX_W-1:0]   out_y,
    output logic [rsdb_pkg::COLOR_W-1:0] out_color,
    output logic                         out_done
);
    import rsdb_pkg::*;

    localparam int SD_W    = $clog2(MAX_SPRITE_DIM + 1);
    localparam int CW      = $clog2(MAX_SPRITE_DIM);
    localparam int RW      = SD_W;
    localparam int DIV_W   = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam int TGT_LIM = (MAX_TARGET_DIM < TARGET_LIMIT) ? MAX_TARGET_DIM : TARGET_LIMIT;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    logic [COUNT_W-1:0]  lit_reg;
    logic [COUNT_W-1:0]  lit_next;
    logic                ov_reg;
    logic                ov_next;
    logic                wr_reg;
    logic                wr_next;
    logic [PIX_W-1:0]    x_reg;
    logic [PIX_W-1:0]    x_next;
    logic [PIX_W-1:0]    y_reg;
    logic [PIX_W-1:0]    y_next;
    logic [COLOR_W-1:0]  color_reg;
    logic [COLOR_W-1:0]  color_next;
    logic                done_reg;
    logic                done_next;

    logic [SD_W-1:0]     w_eff;
    logic [SD_W-1:0]     h_eff;
    logic [12:0]         tw_eff;
    logic [12:0]         th_eff;
    logic                is_pixel;
    logic [COUNT_W-1:0]  step;
    logic [DIV_W-1:0]    c_pos;
    logic                fast0;
    logic                fast1;
    logic [DIV_W-1:0]    q_sel;
    logic [DIV_W-1:0]    r_sel;
    logic [DIV_W:0]      row_sum;
    logic                frame_end;
    logic [16:0]         x_pos;
    logic [16:0]         y_pos;
    logic                visible;
    logic                finish_fast;
    logic                finish_div;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic [SD_W-1:0]     div_r;

    // effective sizes after clamping
    always_comb
    begin
        if (cfg.sprite_width == '0)
        begin
            w_eff = SD_W'(1);
        end
        else if (32'(cfg.sprite_width) > 32'(MAX_SPRITE_DIM))
        begin
            w_eff = SD_W'(MAX_SPRITE_DIM);
        end
        else
        begin
            w_eff = SD_W'(cfg.sprite_width);
        end
        if (cfg.sprite_height == '0)
        begin
            h_eff = SD_W'(1);
        end
        else if (32'(cfg.sprite_height) > 32'(MAX_SPRITE_DIM))
        begin
            h_eff = SD_W'(MAX_SPRITE_DIM);
        end
        else
        begin
            h_eff = SD_W'(cfg.sprite_height);
        end
        tw_eff = (32'(cfg.target_width) > 32'(TGT_LIM)) ? 13'(TGT_LIM) : cfg.target_width;
        th_eff = (32'(cfg.target_height) > 32'(TGT_LIM)) ? 13'(TGT_LIM) : cfg.target_height;
    end

    // pixel position and clipping
    assign x_pos   = {cfg.origin_x[15], cfg.origin_x} + 17'(col_reg);
    assign y_pos   = {cfg.origin_y[15], cfg.origin_y} + 17'(row_reg);
    assign visible = !x_pos[16] && !y_pos[16] &&
                     (x_pos[15:0] < 16'(tw_eff)) && (y_pos[15:0] < 16'(th_eff));

    // advance amount and the wrap fast path
    assign is_pixel = (lit_reg != '0);

    always_comb
    begin
        if (is_pixel)
        begin
            step = COUNT_W'(1);
        end
        else if (q_item.kind == HDR_SKIP)
        begin
            step = q_item.count;
        end
        else
        begin
            step = '0;
        end
    end

    assign c_pos = DIV_W'(col_reg) + DIV_W'(step);
    assign fast0 = (c_pos < DIV_W'(w_eff));
    assign fast1 = ({1'b0, c_pos} < ((DIV_W + 1)'(w_eff) << 1));

    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            q_sel = div_q;
            r_sel = DIV_W'(div_r);
        end
        else if (fast0)
        begin
            q_sel = '0;
            r_sel = c_pos;
        end
        else
        begin
            q_sel = DIV_W'(1);
            r_sel = c_pos - DIV_W'(w_eff);
        end
    end

    assign row_sum   = (DIV_W + 1)'(row_reg) + (DIV_W + 1)'(q_sel);
    assign frame_end = (row_sum >= (DIV_W + 1)'(h_eff));

    // control outputs
    always_comb
    begin
        q_pop       = (state_reg == ST_IDLE) && q_valid && (!ov_reg || out_ready);
        div_start   = q_pop && !fast1;
        finish_fast = q_pop && fast1;
        finish_div  = (state_reg == ST_DIV) && div_done;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        lit_next   = lit_reg;
        ov_next    = ov_reg;
        wr_next    = wr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        done_next  = done_reg;
        if (q_pop)
        begin
            if (is_pixel)
            begin
                lit_next = lit_reg - 1'b1;
            end
            else if (q_item.kind == HDR_LITERAL)
            begin
                lit_next = q_item.count;
            end
            wr_next    = is_pixel && visible;
            x_next     = (is_pixel && visible) ? x_pos[PIX_W-1:0] : '0;
            y_next     = (is_pixel && visible) ? y_pos[PIX_W-1:0] : '0;
            color_next = (is_pixel && visible) ? q_item.word : '0;
            ov_next    = fast1;
            done_next  = frame_end;
        end
        else if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (finish_fast || finish_div)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
                lit_next = '0;
            end
            else
            begin
                col_next = CW'(r_sel);
                row_next = RW'(row_sum);
            end
        end
        if (finish_div)
        begin
            ov_next   = 1'b1;
            done_next = frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            lit_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            lit_reg   <= lit_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg    <= wr_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        done_reg  <= done_next;
    end

    rsdb_div #(
        .DVD_W (DIV_W),
        .DVS_W (SD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (c_pos),
        .divisor   (w_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_valid = ov_reg;
    assign out_wr    = wr_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_color = color_reg;
    assign out_done  = done_reg;

endmodule

### rtl/rsdb_checker.sv
// port-level checks of the sprite decode blitter and their binding
module rsdb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rsdb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);
    import rsdb_pkg::*;

    // stalled result beat stays put
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // queue empty right after reset
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");

    // no result beat right after reset
    a_no_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind rle_sprite_decode_blitter_core rsdb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### test/rsdb_pixel_checker.sv
// predicts every output beat of the sprite decode blitter and compares it with the one seen
module rsdb_pixel_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsdb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsdb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // code_word [15:0]
    input  logic [rsdb_pkg::WORD_W-1:0]      s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x [11:0], pixel_y [23:12], pixel_color [39:24]
    input  logic [rsdb_pkg::OUT_DATA_W-1:0]  m_tdata,
    // write_pixel [0]
    input  logic                             m_tuser,
    input  logic                             m_tlast,
    output int                               pending,
    output int                               fail_count,
    output int                               frames_seen,
    output int                               writes_seen
);
    import rsdb_pkg::*;

    typedef struct packed {
        logic               visible;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [COLOR_W-1:0] color;
        logic               done;
    } pixel_beat_t;

    logic [10:0] reg_sprite_w;
    logic [10:0] reg_sprite_h;
    logic [15:0] reg_origin_x;
    logic [15:0] reg_origin_y;
    logic [12:0] reg_target_w;
    logic [12:0] reg_target_h;

    int column;
    int row;
    int run_left;
    int mismatches;
    int frames;
    int writes;

    pixel_beat_t pixels_due [$];
    pixel_beat_t due;

    function automatic int sprite_dim(input logic [10:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > DEF_MAX_SPRITE_DIM)
            return DEF_MAX_SPRITE_DIM;
        return int'(v);
    endfunction

    function automatic int target_dim(input logic [12:0] v);
        int d;
        d = int'(v);
        if (d > DEF_MAX_TARGET_DIM)
            d = DEF_MAX_TARGET_DIM;
        if (d > TARGET_LIMIT)
            d = TARGET_LIMIT;
        return d;
    endfunction

    // step the position by n pixels, wrapping columns into rows
    function automatic void move_on(input int n);
        int w;
        int c;
        w = sprite_dim(reg_sprite_w);
        c = column + n;
        row = row + c / w;
        column = c % w;
    endfunction

    function automatic pixel_beat_t blit_word(input logic [WORD_W-1:0] word);
        pixel_beat_t r;
        int x;
        int y;
        r = '0;
        if (run_left != 0)
        begin
            x = int'($signed(reg_origin_x)) + column;
            y = int'($signed(reg_origin_y)) + row;
            if (x >= 0 && y >= 0 && x < target_dim(reg_target_w) && y < target_dim(reg_target_h))
            begin
                r.visible = 1'b1;
                r.px      = x[PIX_W-1:0];
                r.py      = y[PIX_W-1:0];
                r.color   = word;
            end
            run_left = run_left - 1;
            move_on(1);
        end
        else if (word[WORD_W-1])
            run_left = int'(word[COUNT_W-1:0]);
        else
            move_on(int'(word[COUNT_W-1:0]));
        // width may have changed since the last word
        move_on(0);
        if (row >= sprite_dim(reg_sprite_h))
        begin
            r.done   = 1'b1;
            column   = 0;
            row      = 0;
            run_left = 0;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_sprite_w = RST_SPRITE_WIDTH;
            reg_sprite_h = RST_SPRITE_HEIGHT;
            reg_origin_x = RST_ORIGIN_X;
            reg_origin_y = RST_ORIGIN_Y;
            reg_target_w = RST_TARGET_WIDTH;
            reg_target_h = RST_TARGET_HEIGHT;
            column       = 0;
            row          = 0;
            run_left     = 0;
            mismatches   = 0;
            frames       = 0;
            writes       = 0;
            pixels_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("output beat with no code word waiting for it");
                    mismatches++;
                end
                else
                begin
                    due = pixels_due.pop_front();
                    compare_field("write_pixel", 16'(due.visible), 16'(m_tuser));
                    compare_field("pixel_x", 16'(due.px), 16'(m_tdata[11:0]));
                    compare_field("pixel_y", 16'(due.py), 16'(m_tdata[23:12]));
                    compare_field("pixel_color", due.color, m_tdata[39:24]);
                    compare_field("frame_done", 16'(due.done), 16'(m_tlast));
                end
                if (m_tlast === 1'b1)
                    frames++;
                if (m_tuser === 1'b1)
                    writes++;
            end
            if (s_tvalid && s_tready)
                pixels_due.push_back(blit_word(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    IDX_SPRITE_WIDTH:  reg_sprite_w = cfg_data[10:0];
                    IDX_SPRITE_HEIGHT: reg_sprite_h = cfg_data[10:0];
                    IDX_ORIGIN_X:      reg_origin_x = cfg_data;
                    IDX_ORIGIN_Y:      reg_origin_y = cfg_data;
                    IDX_TARGET_WIDTH:  reg_target_w = cfg_data[12:0];
                    IDX_TARGET_HEIGHT: reg_target_h = cfg_data[12:0];
                    default:           ;
                endcase
            end
        end
        pending     <= pixels_due.size();
        fail_count  <= mismatches;
        frames_seen <= frames;
        writes_seen <= writes;
    end

endmodule

### test/rle_sprite_decode_blitter_core_tb.sv
// stimulus, handshake pressure and verdict for the run-length sprite decode blitter
module rle_sprite_decode_blitter_core_tb;
    import rsdb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 900;
    localparam logic [15:0] DIRECTED_WORDS [20] = '{
        16'h0000, 16'h8000, 16'h8003, 16'h0000, 16'hFFFF,
        16'h5A5A, 16'h0002, 16'h8002, 16'hA5A5, 16'h1234,
        16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
        16'h00FF, 16'h7FFF, 16'h8002, 16'hC0DE, 16'hBEEF
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    int pending;
    int mismatches;
    int frames_seen;
    int writes_seen;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int hold_req         = 0;
    int hold_left        = 0;
    int cycles           = 0;
    int words_fed        = 0;
    int settings_applied = 0;
    int phase            = 0;
    int max_run          = 0;
    int max_skip         = 0;

    rle_sprite_decode_blitter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsdb_pixel_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .pending     (pending),
        .fail_count  (mismatches),
        .frames_seen (frames_seen),
        .writes_seen (writes_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side: random stalls, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_fed++;
    endtask

    // drop valid and wait for every outstanding beat, plus the divider's latency
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (24) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] sw, input logic [15:0] sh,
                                 input logic [15:0] ox, input logic [15:0] oy,
                                 input logic [15:0] tw, input logic [15:0] th);
        settle();
        cfg_beat(IDX_SPRITE_WIDTH, sw);
        cfg_beat(IDX_SPRITE_HEIGHT, sh);
        cfg_beat(IDX_ORIGIN_X, ox);
        cfg_beat(IDX_ORIGIN_Y, oy);
        cfg_beat(IDX_TARGET_WIDTH, tw);
        cfg_beat(IDX_TARGET_HEIGHT, th);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // mostly well-formed runs and skips with random colours, some noise
    task automatic feed_stream(input int n_words);
        int sent;
        int pick;
        int k;
        sent = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                k = $urandom_range(max_run);
                send_word({1'b1, 15'(k)});
                repeat (k) send_word(16'($urandom));
                sent += k + 1;
            end
            else if (pick < 80)
            begin
                k = $urandom_range(max_skip);
                send_word({1'b0, 15'(k)});
                sent++;
            end
            else if (pick < 92)
            begin
                send_word(16'($urandom));
                sent++;
            end
            else if (pick < 97)
            begin
                send_word({1'($urandom_range(1)), 15'h0000});
                sent++;
            end
            else
            begin
                send_word({1'($urandom_range(1)), 15'h7FFF});
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clipping at the right and bottom target edges
        apply_setting(16'd4, 16'd3, 16'd318, 16'd238, 16'd320, 16'd240);
        foreach (DIRECTED_WORDS[i])
            send_word(DIRECTED_WORDS[i]);

        while (words_fed < $size(DIRECTED_WORDS) + RANDOM_WORDS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            max_run  = 10;
            max_skip = 40;
            case (phase)
                0: apply_setting(16'd5, 16'd4, 16'd0, 16'd0, 16'd320, 16'd240);
                1:
                begin
                    apply_setting(16'd1, 16'd1, 16'h8000, 16'h7FFF, 16'd1, 16'd1);
                    max_run  = 4;
                    max_skip = 4;
                end
                2:
                begin
                    apply_setting(16'd0, 16'd0, 16'hFFFE, 16'hFFFF, 16'd0, 16'd5);
                    max_run  = 6;
                    max_skip = 6;
                end
                3:
                begin
                    apply_setting(16'd1024, 16'd1024, 16'd4090, 16'd4090, 16'd4096, 16'd4096);
                    max_run  = 40;
                    max_skip = 32767;
                end
                4:
                begin
                    apply_setting(16'hFFFF, 16'hF803, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hE005);
                    max_run  = 40;
                    max_skip = 32767;
                end
                5: apply_setting(16'd7, 16'd5, 16'd4093, 16'hFFFD, 16'd4096, 16'd4096);
                6:
                begin
                    apply_setting(16'd13, 16'd6, 16'hFFFB, 16'd2, 16'd10, 16'd6);
                    max_run  = 16;
                    max_skip = 80;
                end
                7:
                begin
                    apply_setting(16'd3, 16'd2, 16'd0, 16'd0, 16'd3, 16'd1);
                    max_run  = 6;
                    max_skip = 8;
                end
                default:
                    apply_setting(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(40) - 20), 16'($urandom_range(40) - 20),
                                  16'($urandom_range(24)), 16'($urandom_range(24)));
            endcase
            if (phase == 7)
            begin
                // receiver holds off while the sender keeps pushing
                send_idle_pct = 0;
                hold_req      = 300;
                feed_stream(60);
                settle();
                feed_stream(50);
            end
            else
                feed_stream(110);
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (pending != 0)
            $error("%0d expected output beats never arrived", pending);
        $display("fed %0d code words over %0d register settings and %0d idle/stall phases",
                 words_fed, settings_applied, phase);
        $display("%0d output beats carried a visible pixel, %0d closed a frame",
                 writes_seen, frames_seen);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
